[hw/rtl/assert_macros.svh]
// assertion helpers for the dispense supervisor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define WDS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define WDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hw/rtl/wds_pkg.sv]
// ---------------------------------------------------------------------------
// wds_pkg
// shared types and codes of the dispense supervisor
// ---------------------------------------------------------------------------
package wds_pkg;
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_FAULT = 2'd2;
   localparam logic [1:0] KIND_TICK  = 2'd3;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_REJECT = 2'd1;
   localparam logic [1:0] ACT_BURST  = 2'd2;
   localparam logic [1:0] ACT_DONE   = 2'd3;

   localparam logic [1:0] OUT_SUCCESS   = 2'd0;
   localparam logic [1:0] OUT_STUCK     = 2'd1;
   localparam logic [1:0] OUT_UNDERFILL = 2'd2;
   localparam logic [1:0] OUT_ABORTED   = 2'd3;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_MOTOR  = 2'd1;
   localparam logic [1:0] PH_SETTLE = 2'd2;

   localparam logic [2:0] REG_CLOSED = 3'd0;
   localparam logic [2:0] REG_GPP    = 3'd1;
   localparam logic [2:0] REG_TOL    = 3'd2;
   localparam logic [2:0] REG_MAXB   = 3'd3;
   localparam logic [2:0] REG_ZGL    = 3'd4;
   localparam logic [2:0] REG_SETTLE = 3'd5;
   localparam logic [2:0] REG_PMAX   = 3'd6;
   localparam logic [2:0] REG_GMAX   = 3'd7;

   localparam int DivSteps = 17;

   typedef struct packed {
      logic [1:0]  kind;
      logic        request_kind;
      logic [7:0]  target;
      logic        from_uart;
      logic [31:0] now_ms;
      logic [15:0] weight_grams;
      logic        weight_valid;
      logic        weight_trusted;
      logic        motor_ok;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        event_taken;
      logic [7:0]  pulse_count;
      logic [15:0] delivered_grams;
      logic        delivered_is_estimate;
      logic [1:0]  outcome;
      logic [7:0]  batches_used;
      logic [7:0]  portions_total;
      logic [15:0] goal_grams;
      logic        busy_res;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic div_start;  // begin division
      logic div_step;   // one quotient bit
      logic commit;     // apply step, build result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } sts_type;
endpackage

[hw/rtl/wds_stream_if.sv]
// ---------------------------------------------------------------------------
// wds_stream_if
// valid/ready channel carrying one payload
// ---------------------------------------------------------------------------
interface wds_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/wds_datapath.sv]
// ---------------------------------------------------------------------------
// wds_datapath
// job state, config registers, shared restoring divider and decisions
// ---------------------------------------------------------------------------
module wds_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  wds_pkg::req_type    req_data,
   input  wds_pkg::cmd_type    cmd,
   output wds_pkg::sts_type    sts,
   output wds_pkg::rsp_type    result
);
   logic        closed_ff;
   logic [7:0]  gpp_ff, tol_ff, maxb_ff, zgl_ff, pmax_ff, gmax_ff;
   logic [15:0] settle_ff;

   logic [1:0]  phase_ff, pend_ff;
   logic        open_ff, bok_ff, stime_ff;
   logic [15:0] tgt_ff;
   logic [7:0]  port_ff, bat_ff, zgs_ff;
   logic [15:0] base_ff, prev_ff;
   logic [31:0] sbeg_ff;

   wds_pkg::req_type r_ff;
   logic [16:0] rem_ff, quo_ff, dvd_ff;
   logic [4:0]  cnt_ff;

   logic [7:0]  gpp, pmax;
   assign gpp  = (gpp_ff == 8'd0) ? 8'd1 : gpp_ff;
   assign pmax = (pmax_ff == 8'd0) ? 8'd1 : pmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= 1'b1; gpp_ff <= 8'd5; tol_ff <= 8'd2; maxb_ff <= 8'd3;
         zgl_ff <= 8'd2; settle_ff <= 16'd1500; pmax_ff <= 8'd10; gmax_ff <= 8'd100;
      end else if (csr_we) begin
         unique case (csr_index)
            wds_pkg::REG_CLOSED: closed_ff <= csr_wdata[0];
            wds_pkg::REG_GPP:    gpp_ff <= csr_wdata[7:0];
            wds_pkg::REG_TOL:    tol_ff <= csr_wdata[7:0];
            wds_pkg::REG_MAXB:   maxb_ff <= csr_wdata[7:0];
            wds_pkg::REG_ZGL:    zgl_ff <= csr_wdata[7:0];
            wds_pkg::REG_SETTLE: settle_ff <= csr_wdata;
            wds_pkg::REG_PMAX:   pmax_ff <= csr_wdata[7:0];
            wds_pkg::REG_GMAX:   gmax_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // measurement terms of the settle reading
   logic signed [17:0] w, delivered, bdelta, thresh;
   logic measured, div_grams, div_tick;
   assign w         = 18'(signed'(r_ff.weight_grams));
   assign delivered = w - 18'(signed'(base_ff));
   assign bdelta    = w - 18'(signed'(prev_ff));
   assign thresh    = signed'({2'b00, tgt_ff}) - signed'({10'd0, tol_ff});
   assign measured  = bok_ff & r_ff.weight_valid & r_ff.weight_trusted;
   logic [31:0] elapsed;
   assign elapsed = r_ff.now_ms - sbeg_ff;

   logic [7:0] zgs_new;
   always_comb begin
      if (bdelta <= 18'sd0) zgs_new = (zgs_ff == 8'd255) ? zgs_ff : zgs_ff + 8'd1;
      else zgs_new = 8'd0;
   end

   // does this item need the divider
   logic settle_go, extra_path;
   assign settle_go = r_ff.kind == wds_pkg::KIND_TICK && phase_ff == wds_pkg::PH_SETTLE
                      && stime_ff && elapsed >= {16'd0, settle_ff};
   assign extra_path = settle_go && measured && pend_ff != wds_pkg::OUT_STUCK && !open_ff
                      && !(delivered >= thresh)
                      && !(bat_ff >= maxb_ff || zgs_new >= zgl_ff);
   assign div_grams = r_ff.kind == wds_pkg::KIND_START && r_ff.request_kind;
   assign div_tick  = extra_path;
   assign sts.need_div = div_grams || div_tick;
   assign sts.div_done = cnt_ff == 5'd0;

   logic [16:0] dvd_sel, trial;
   always_comb begin
      if (div_grams) dvd_sel = 17'({9'd0, r_ff.target} + {9'd0, gpp} - 17'd1);
      else dvd_sel = 17'(18'(signed'({2'b00, tgt_ff})) - delivered);
   end
   assign trial = {rem_ff[15:0], dvd_ff[16]};

   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req_data;
      if (cmd.div_start) begin
         dvd_ff <= dvd_sel; rem_ff <= 17'd0; quo_ff <= 17'd0;
         cnt_ff <= 5'(wds_pkg::DivSteps);
      end else if (cmd.div_step && cnt_ff != 5'd0) begin
         dvd_ff <= {dvd_ff[15:0], 1'b0};
         if (trial >= {9'd0, gpp}) begin
            rem_ff <= trial - {9'd0, gpp}; quo_ff <= {quo_ff[15:0], 1'b1};
         end else begin
            rem_ff <= trial; quo_ff <= {quo_ff[15:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 5'd1;
      end
   end

   // result and next state of one item
   wds_pkg::rsp_type res;
   logic [1:0]  phase_n, pend_n;
   logic        open_n, bok_n, stime_n;
   logic [15:0] tgt_n, base_n, prev_n;
   logic [7:0]  port_n, bat_n, zgs_n, extra;
   logic [31:0] sbeg_n;
   logic [15:0] est, evg;
   logic [8:0]  psum;

   always_comb begin
      res = '0;
      phase_n = phase_ff; pend_n = pend_ff; open_n = open_ff; bok_n = bok_ff;
      stime_n = stime_ff; tgt_n = tgt_ff; base_n = base_ff; prev_n = prev_ff;
      port_n = port_ff; bat_n = bat_ff; zgs_n = zgs_ff; sbeg_n = sbeg_ff;
      est = {8'd0, port_ff} * {8'd0, gpp};
      evg = measured ? ((delivered < 0) ? 16'd0 : delivered[15:0]) : est;
      extra = (quo_ff > 17'd255) ? 8'd255 : quo_ff[7:0];
      psum = 9'd0;
      case (r_ff.kind)
         wds_pkg::KIND_START: begin
            if (phase_ff != wds_pkg::PH_IDLE) res.action = wds_pkg::ACT_REJECT;
            else if (r_ff.request_kind && (r_ff.target == 8'd0 || r_ff.target > gmax_ff))
               res.action = wds_pkg::ACT_REJECT;
            else if (!r_ff.request_kind && (r_ff.target == 8'd0 || r_ff.target > pmax))
               res.action = wds_pkg::ACT_REJECT;
            else if (!r_ff.motor_ok) res.action = wds_pkg::ACT_REJECT;
            else begin
               if (r_ff.request_kind) begin
                  port_n = (quo_ff > {9'd0, pmax}) ? pmax : quo_ff[7:0];
                  if (port_n == 8'd0) port_n = 8'd1;
                  tgt_n = {8'd0, r_ff.target};
               end else begin
                  port_n = r_ff.target;
                  tgt_n = {8'd0, r_ff.target} * {8'd0, gpp};
               end
               open_n = (!r_ff.request_kind && r_ff.from_uart) || !closed_ff;
               bat_n = 8'd1; zgs_n = 8'd0; pend_n = wds_pkg::OUT_SUCCESS;
               bok_n = r_ff.weight_valid & r_ff.weight_trusted;
               base_n = bok_n ? r_ff.weight_grams : 16'd0;
               prev_n = base_n; stime_n = 1'b0; phase_n = wds_pkg::PH_MOTOR;
               res.action = wds_pkg::ACT_BURST; res.pulse_count = port_n;
               res.batches_used = bat_n; res.portions_total = port_n;
               res.goal_grams = tgt_n;
            end
         end
         wds_pkg::KIND_DONE, wds_pkg::KIND_FAULT: begin
            if (phase_ff == wds_pkg::PH_MOTOR) begin
               pend_n = (r_ff.kind == wds_pkg::KIND_DONE) ? wds_pkg::OUT_SUCCESS
                                                          : wds_pkg::OUT_STUCK;
               phase_n = wds_pkg::PH_SETTLE; stime_n = 1'b0; res.event_taken = 1'b1;
            end
         end
         default: begin
            if (phase_ff == wds_pkg::PH_SETTLE) begin
               if (!stime_ff) begin
                  sbeg_n = r_ff.now_ms; stime_n = 1'b1;
               end else if (settle_go) begin
                  if (measured) begin
                     zgs_n = zgs_new; prev_n = r_ff.weight_grams;
                  end
                  res.batches_used = bat_ff; res.portions_total = port_ff;
                  res.goal_grams = tgt_ff; res.delivered_grams = evg;
                  res.action = wds_pkg::ACT_DONE;
                  phase_n = wds_pkg::PH_IDLE; stime_n = 1'b0;
                  if (pend_ff == wds_pkg::OUT_STUCK || open_ff || !measured) begin
                     res.outcome = pend_ff; res.delivered_is_estimate = !measured;
                  end else if (delivered >= thresh) res.outcome = wds_pkg::OUT_SUCCESS;
                  else if (bat_ff >= maxb_ff || zgs_new >= zgl_ff)
                     res.outcome = wds_pkg::OUT_UNDERFILL;
                  else begin
                     if (extra == 8'd0) extra = 8'd1;
                     if (extra > pmax) extra = pmax;
                     if (!r_ff.motor_ok) res.outcome = wds_pkg::OUT_ABORTED;
                     else begin
                        psum = {1'b0, port_ff} + {1'b0, extra};
                        port_n = psum[8] ? 8'd255 : psum[7:0];
                        bat_n = (bat_ff == 8'd255) ? bat_ff : bat_ff + 8'd1;
                        phase_n = wds_pkg::PH_MOTOR;
                        res = '0;
                        res.action = wds_pkg::ACT_BURST; res.pulse_count = extra;
                        res.batches_used = bat_n; res.portions_total = port_n;
                        res.goal_grams = tgt_ff;
                     end
                  end
                  pend_n = (res.action == wds_pkg::ACT_DONE) ? res.outcome : pend_ff;
               end
            end
         end
      endcase
      res.busy_res = phase_n != wds_pkg::PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wds_pkg::PH_IDLE; pend_ff <= wds_pkg::OUT_SUCCESS; open_ff <= 1'b1;
         tgt_ff <= '0; port_ff <= '0; bat_ff <= '0; base_ff <= '0; bok_ff <= 1'b0;
         prev_ff <= '0; sbeg_ff <= '0; stime_ff <= 1'b0; zgs_ff <= '0;
      end else if (cmd.commit) begin
         phase_ff <= phase_n; pend_ff <= pend_n; open_ff <= open_n; tgt_ff <= tgt_n;
         port_ff <= port_n; bat_ff <= bat_n; base_ff <= base_n; bok_ff <= bok_n;
         prev_ff <= prev_n; sbeg_ff <= sbeg_n; stime_ff <= stime_n; zgs_ff <= zgs_n;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) result <= res;
   end
endmodule

[hw/rtl/wds_control.sv]
// ---------------------------------------------------------------------------
// wds_control
// sequencer: accept, divide if needed, commit, hold result
// ---------------------------------------------------------------------------
module wds_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  wds_pkg::sts_type sts,
   output wds_pkg::cmd_type cmd
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_EVAL = 4'b0010, ST_DIV = 4'b0100, ST_OUT = 4'b1000
   } state_type;
   state_type state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1; state_in = ST_DIV;
            end else begin
               cmd.commit = 1'b1; state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.commit = 1'b1; state_in = ST_OUT;
            end else cmd.div_step = 1'b1;
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

[hw/rtl/weighed_dispense_supervisor.sv]
// ---------------------------------------------------------------------------
// weighed_dispense_supervisor
// supervises one weighed feed dispense job
// ---------------------------------------------------------------------------
// req carries start requests, motor events and ticks; rsp returns exactly
// one result transaction per request transaction. csr writes the eight
// configuration registers by index; the user must write them only while no
// transaction is in flight, which the block itself does not enforce. With
// no division the EVAL state commits the result to the output register,
// which is held valid in the OUT state. A grams target or an extra burst
// runs the 17-step restoring divider (one quotient bit per cycle) first.
// One item is in work at a time; req_ready is low from accept until the
// result is taken.
// A stalled rsp holds its result and keeps req_ready low.
// Synchronous reset returns the job to idle and loads register defaults.
`include "assert_macros.svh"
module weighed_dispense_supervisor (
   input  logic        clock,
   input  logic        reset,
   wds_stream_if.sink   req,
   wds_stream_if.source rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   wds_pkg::cmd_type cmd;
   wds_pkg::sts_type sts;

   wds_control u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .sts, .cmd
   );

   wds_datapath u_dp (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_data(req.data), .cmd, .sts, .result(rsp.data)
   );

   `WDS_ASSERT_IMPL(a_no_overlap, clock, reset, rsp.valid, !req.ready)
   `WDS_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp.valid)
   `WDS_ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1,
      $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.commit}))
endmodule
